// ----- src/dfu_pkg.sv -----
// Shared types, codes and constants of the DFU download sequencer.
package dfu_pkg;

  localparam int PACKET_BYTES = 1024;

  localparam int CMD_W   = 2;
  localparam int LENGTH_W = 32;
  localparam int DSTATE_W = 8;
  localparam int WAIT_W  = 24;
  localparam int BLK_W   = 16;
  localparam int LEN_W   = 11;
  localparam int ERR_W   = 3;
  localparam int PADDR_W = 3;

  localparam logic [WAIT_W-1:0]   WAIT_MAX   = '1;
  localparam logic [LENGTH_W-1:0] PACKET_LEN = LENGTH_W'(PACKET_BYTES);

  // commands of an input word
  localparam logic [CMD_W-1:0] CMD_START  = 2'd0;
  localparam logic [CMD_W-1:0] CMD_STATE  = 2'd1;
  localparam logic [CMD_W-1:0] CMD_STATUS = 2'd2;
  localparam logic [CMD_W-1:0] CMD_ACK    = 2'd3;

  // requests of a result word
  localparam logic [1:0] REQ_NONE       = 2'd0;
  localparam logic [1:0] REQ_GET_STATE  = 2'd1;
  localparam logic [1:0] REQ_GET_STATUS = 2'd2;
  localparam logic [1:0] REQ_DNLOAD     = 2'd3;

  localparam logic [ERR_W-1:0] ERR_NONE       = 3'd0;
  localparam logic [ERR_W-1:0] ERR_BAD_LENGTH = 3'd1;
  localparam logic [ERR_W-1:0] ERR_XFER_FAIL  = 3'd2;
  localparam logic [ERR_W-1:0] ERR_DEVICE     = 3'd3;
  localparam logic [ERR_W-1:0] ERR_UNKNOWN    = 3'd4;
  localparam logic [ERR_W-1:0] ERR_UNEXPECTED = 3'd5;

  // DFU device states
  localparam logic [DSTATE_W-1:0] DS_DFU_IDLE        = 8'h02;
  localparam logic [DSTATE_W-1:0] DS_DNLOAD_SYNC     = 8'h03;
  localparam logic [DSTATE_W-1:0] DS_DNBUSY          = 8'h04;
  localparam logic [DSTATE_W-1:0] DS_DNLOAD_IDLE     = 8'h05;
  localparam logic [DSTATE_W-1:0] DS_MANIFEST_SYNC   = 8'h06;
  localparam logic [DSTATE_W-1:0] DS_MANIFEST        = 8'h07;
  localparam logic [DSTATE_W-1:0] DS_MANIFEST_WAIT   = 8'h08;
  localparam logic [DSTATE_W-1:0] DS_DFU_ERROR       = 8'h0a;

  localparam logic [PADDR_W-1:0] ADDR_MANIFEST_WAIT = 3'd0;

  typedef enum logic [1:0] {
    PH_IDLE   = 2'd0,
    PH_STATE  = 2'd1,
    PH_STATUS = 2'd2,
    PH_ACK    = 2'd3
  } phase_t;

  typedef struct packed {
    logic [CMD_W-1:0]    command;
    logic [LENGTH_W-1:0] image_length;
    logic [DSTATE_W-1:0] device_state;
    logic [WAIT_W-1:0]   poll_timeout_ms;
    logic                transfer_ok;
  } item_t;

  typedef struct packed {
    logic [1:0]          request;
    logic [BLK_W-1:0]    block_number;
    logic [LENGTH_W-1:0] buffer_offset;
    logic [LEN_W-1:0]    block_length;
    logic [WAIT_W-1:0]   wait_ms;
    logic                finished;
    logic [ERR_W-1:0]    error_code;
  } result_t;

  typedef struct packed {
    phase_t              phase;
    logic                in_manifest_sync;
    logic [LENGTH_W-1:0] bytes_remaining;
    logic [LENGTH_W-1:0] next_offset;
    logic [BLK_W-1:0]    block_counter;
    logic [WAIT_W-1:0]   last_timeout;
  } seq_state_t;

endpackage

// ----- src/dfu_if.sv -----
// Valid/ready channel interfaces for the sequencer input and result words.
interface dfu_item_if;
  import dfu_pkg::*;

  logic                valid;
  logic                ready;
  logic [CMD_W-1:0]    command;
  logic [LENGTH_W-1:0] image_length;
  logic [DSTATE_W-1:0] device_state;
  logic [WAIT_W-1:0]   poll_timeout_ms;
  logic                transfer_ok;

  modport source (
    output valid, command, image_length, device_state, poll_timeout_ms, transfer_ok,
    input  ready
  );
  modport sink (
    input  valid, command, image_length, device_state, poll_timeout_ms, transfer_ok,
    output ready
  );
endinterface

interface dfu_result_if;
  import dfu_pkg::*;

  logic                valid;
  logic                ready;
  logic [1:0]          request;
  logic [BLK_W-1:0]    block_number;
  logic [LENGTH_W-1:0] buffer_offset;
  logic [LEN_W-1:0]    block_length;
  logic [WAIT_W-1:0]   wait_ms;
  logic                finished;
  logic [ERR_W-1:0]    error_code;

  modport source (
    output valid, request, block_number, buffer_offset, block_length, wait_ms,
           finished, error_code,
    input  ready
  );
  modport sink (
    input  valid, request, block_number, buffer_offset, block_length, wait_ms,
           finished, error_code,
    output ready
  );
endinterface

// ----- src/dfu_step.sv -----
// One sequencer step: next state and result word for one input word.
module dfu_step (
  input  dfu_pkg::seq_state_t          st,
  input  dfu_pkg::item_t               itm,
  input  logic [dfu_pkg::WAIT_W-1:0]   manifest_wait_ms,
  output dfu_pkg::seq_state_t          st_next,
  output dfu_pkg::result_t             res
);
  import dfu_pkg::*;

  typedef enum logic [2:0] {
    ACT_START,
    ACT_BAD_LENGTH,
    ACT_UNEXPECTED,
    ACT_XFER_FAIL,
    ACT_ACK,
    ACT_DISPATCH
  } action_t;

  typedef enum logic [2:0] {
    DISP_BLOCK,
    DISP_STATUS,
    DISP_BUSY,
    DISP_DONE,
    DISP_DEV_ERROR,
    DISP_UNKNOWN
  } disp_t;

  action_t             action;
  disp_t               disp;
  logic [WAIT_W-1:0]   status_to;
  logic [WAIT_W-1:0]   prewait;
  logic [WAIT_W-1:0]   timeout_eff;
  logic [WAIT_W:0]     busy_sum;
  logic [WAIT_W-1:0]   busy_wait;
  logic [LENGTH_W-1:0] take;
  logic                is_status;

  assign is_status = (itm.command == CMD_STATUS);

  // timeout recorded by a status reply; manifest sync may override it
  always_comb begin
    status_to = itm.poll_timeout_ms;
    if (st.in_manifest_sync && (manifest_wait_ms != '0)) begin
      status_to = manifest_wait_ms;
    end
  end

  assign prewait     = (is_status && st.in_manifest_sync) ? status_to : '0;
  assign timeout_eff = is_status ? status_to : st.last_timeout;
  assign busy_sum    = {1'b0, prewait} + {1'b0, timeout_eff};
  assign busy_wait   = busy_sum[WAIT_W] ? WAIT_MAX : busy_sum[WAIT_W-1:0];
  assign take        = (st.bytes_remaining <= PACKET_LEN) ? st.bytes_remaining : PACKET_LEN;

  always_comb begin
    if (itm.command == CMD_START) begin
      action = (itm.image_length == '0) ? ACT_BAD_LENGTH : ACT_START;
    end else if (itm.command != st.phase) begin
      action = ACT_UNEXPECTED;
    end else if (!itm.transfer_ok) begin
      action = ACT_XFER_FAIL;
    end else if (itm.command == CMD_ACK) begin
      action = ACT_ACK;
    end else begin
      action = ACT_DISPATCH;
    end
  end

  always_comb begin
    case (itm.device_state)
      DS_DFU_IDLE, DS_DNLOAD_IDLE:       disp = DISP_BLOCK;
      DS_DNLOAD_SYNC, DS_MANIFEST_SYNC:  disp = DISP_STATUS;
      DS_DNBUSY:                         disp = DISP_BUSY;
      DS_MANIFEST, DS_MANIFEST_WAIT:     disp = DISP_DONE;
      DS_DFU_ERROR:                      disp = DISP_DEV_ERROR;
      default:                           disp = DISP_UNKNOWN;
    endcase
  end

  // next state
  always_comb begin
    st_next = st;
    case (action)
      ACT_START: begin
        st_next.phase            = PH_STATE;
        st_next.in_manifest_sync = 1'b0;
        st_next.bytes_remaining  = itm.image_length;
        st_next.next_offset      = '0;
        st_next.block_counter    = '0;
        st_next.last_timeout     = '0;
      end
      ACT_BAD_LENGTH, ACT_UNEXPECTED, ACT_XFER_FAIL: begin
        st_next.phase = PH_IDLE;
      end
      ACT_ACK: begin
        st_next.phase = PH_STATE;
      end
      ACT_DISPATCH: begin
        if (is_status) begin
          st_next.last_timeout = status_to;
        end
        case (disp)
          DISP_BLOCK: begin
            st_next.bytes_remaining = st.bytes_remaining - take;
            st_next.next_offset     = st.next_offset + take;
            st_next.block_counter   = st.block_counter + BLK_W'(1);
            st_next.phase           = PH_ACK;
          end
          DISP_STATUS: begin
            st_next.in_manifest_sync = (itm.device_state == DS_MANIFEST_SYNC);
            st_next.phase            = PH_STATUS;
          end
          DISP_BUSY: begin
            st_next.phase = PH_STATE;
          end
          default: begin
            st_next.phase = PH_IDLE;
          end
        endcase
      end
      default: begin
        st_next = st;
      end
    endcase
  end

  // result word
  always_comb begin
    res = '0;
    case (action)
      ACT_START, ACT_ACK: begin
        res.request = REQ_GET_STATE;
      end
      ACT_BAD_LENGTH: begin
        res.finished   = 1'b1;
        res.error_code = ERR_BAD_LENGTH;
      end
      ACT_UNEXPECTED: begin
        res.finished   = 1'b1;
        res.error_code = ERR_UNEXPECTED;
      end
      ACT_XFER_FAIL: begin
        res.finished   = 1'b1;
        res.error_code = ERR_XFER_FAIL;
      end
      ACT_DISPATCH: begin
        res.wait_ms = prewait;
        case (disp)
          DISP_BLOCK: begin
            res.request       = REQ_DNLOAD;
            res.block_number  = st.block_counter;
            res.buffer_offset = st.next_offset;
            res.block_length  = take[LEN_W-1:0];
          end
          DISP_STATUS: begin
            res.request = REQ_GET_STATUS;
          end
          DISP_BUSY: begin
            res.request = REQ_GET_STATE;
            res.wait_ms = busy_wait;
          end
          DISP_DONE: begin
            res.finished = 1'b1;
          end
          DISP_DEV_ERROR: begin
            res.finished   = 1'b1;
            res.error_code = ERR_DEVICE;
          end
          default: begin
            res.finished   = 1'b1;
            res.error_code = ERR_UNKNOWN;
          end
        endcase
      end
      default: begin
        res = '0;
      end
    endcase
  end

endmodule

// ----- src/dfu_download_sequencer_top.sv -----
// Top level of the DFU download sequencer: channels, config register, result buffer.
//
// Host-side sequencer for a USB DFU firmware download. The item channel
// takes one word per event: a start with the image length, or a device
// reply (state report, status report with poll timeout, block ack).
// Each accepted word yields exactly one word on the result channel: the
// next request (get state, get status, download block with number,
// offset and length), or a finished word with an error code, plus a wait
// in milliseconds to honor before acting on it.
// The result word is registered on accept; one word per cycle is taken
// sustained unless the result side below is full.
// The result side has an output register and a one-word skid register,
// so a word is still taken while the first result waits; item ready
// drops only when both are full, and rises again once the receiver
// takes a word. Results are never dropped or reordered.
// The APB port holds manifest_wait_ms at address 0 (pready tied high).
// Synchronous reset returns the sequence to idle, clears all counters
// and the config register, and empties the result buffer.
module dfu_download_sequencer_top (
  input  logic                          clk,
  input  logic                          rst,
  dfu_item_if.sink                      item,
  dfu_result_if.source                  result,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [dfu_pkg::PADDR_W-1:0]   paddr,
  input  logic [31:0]                   pwdata,
  output logic [31:0]                   prdata,
  output logic                          pready
);
  import dfu_pkg::*;

  seq_state_t        st;
  seq_state_t        st_next;
  item_t             itm;
  result_t           res;
  result_t           out_word;
  result_t           skid_word;
  logic              out_valid;
  logic              skid_valid;
  logic              accept;
  logic              out_free;
  logic              reg_hit;
  logic [WAIT_W-1:0] manifest_wait_ms;

  assign itm.command         = item.command;
  assign itm.image_length    = item.image_length;
  assign itm.device_state    = item.device_state;
  assign itm.poll_timeout_ms = item.poll_timeout_ms;
  assign itm.transfer_ok     = item.transfer_ok;

  dfu_step u_step (
    .st               (st),
    .itm              (itm),
    .manifest_wait_ms (manifest_wait_ms),
    .st_next          (st_next),
    .res              (res)
  );

  assign item.ready = !skid_valid;
  assign accept     = item.valid && !skid_valid;
  assign out_free   = !out_valid || result.ready;

  // APB register
  assign reg_hit = (paddr[PADDR_W-1] == ADDR_MANIFEST_WAIT[PADDR_W-1]);
  assign pready  = 1'b1;
  assign prdata  = reg_hit ? {{(32-WAIT_W){1'b0}}, manifest_wait_ms} : '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      manifest_wait_ms <= '0;
    end else if (psel && penable && pwrite && reg_hit) begin
      manifest_wait_ms <= pwdata[WAIT_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      st         <= '{phase: PH_IDLE, in_manifest_sync: 1'b0, bytes_remaining: '0,
                      next_offset: '0, block_counter: '0, last_timeout: '0};
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else begin
      if (accept) begin
        st <= st_next;
      end
      if (out_free) begin
        if (skid_valid) begin
          out_valid  <= 1'b1;
          skid_valid <= 1'b0;
        end else begin
          out_valid <= accept;
        end
      end else if (accept) begin
        skid_valid <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (out_free) begin
      if (skid_valid) begin
        out_word <= skid_word;
      end else if (accept) begin
        out_word <= res;
      end
    end else if (accept) begin
      skid_word <= res;
    end
  end

  assign result.valid         = out_valid;
  assign result.request       = out_word.request;
  assign result.block_number  = out_word.block_number;
  assign result.buffer_offset = out_word.buffer_offset;
  assign result.block_length  = out_word.block_length;
  assign result.wait_ms       = out_word.wait_ms;
  assign result.finished      = out_word.finished;
  assign result.error_code    = out_word.error_code;

`ifndef ASSERT_OFF
  a_skid_implies_out: assert property (@(posedge clk) disable iff (rst)
    skid_valid |-> out_valid)
    else $error("skid word held with empty output register");

  a_stall_fills_skid: assert property (@(posedge clk) disable iff (rst)
    (accept && out_valid && !result.ready) |=> skid_valid)
    else $error("word accepted during stall not parked in skid register");

  a_finish_to_idle: assert property (@(posedge clk) disable iff (rst)
    (accept && res.finished) |=> (st.phase == PH_IDLE))
    else $error("finished word did not return sequence to idle");

  a_finish_no_request: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_word.finished) |-> (out_word.request == REQ_NONE))
    else $error("finished word carries a request");

  a_block_fields_zero: assert property (@(posedge clk) disable iff (rst)
    (out_valid && (out_word.request != REQ_DNLOAD)) |->
      ((out_word.block_number == '0) && (out_word.buffer_offset == '0) &&
       (out_word.block_length == '0)))
    else $error("block fields set on a non-download word");
`endif

endmodule
